### rtl/core/hhpd_pkg.sv
// Shared widths, constants, register indexes and unit handshake types for the
// heading-hold drive block. No dependencies; every other file imports this.
`timescale 1ns / 1ps
`default_nettype none

package hhpd_pkg;

  // Port field widths
  localparam int HEAD_W     = 13;
  localparam int MS_W       = 16;
  localparam int PWM_W      = 8;
  localparam int CORR_W     = 9;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal datapath widths
  localparam int HDIFF_W  = HEAD_W + 1;      // raw heading difference
  localparam int DE_W     = HEAD_W + 1;      // error delta
  localparam int INTEG_W  = 21;              // integral accumulator
  localparam int ISUM_W   = 30;              // integral plus e*dt before clamp
  localparam int EDT_W    = 29;              // e*dt product
  localparam int GIDT_W   = 32;              // gain_i*dt product
  localparam int GDDE_W   = 30;              // gain_d*de product
  localparam int T_W      = 26;              // gain_p*1000 and dt*1000
  localparam int MA_W     = 34;              // multiplier operand a
  localparam int MB_W     = 30;              // multiplier operand b
  localparam int PROD_W   = 56;              // kept product / accumulator
  localparam int DEN_SHIFT = 12;             // 4096000 = 1000 << 12
  localparam int DEN_W    = T_W + DEN_SHIFT;
  localparam int QUOT_W   = 10;
  localparam int REM_W    = PROD_W - 1;
  localparam int DIVS_W   = DEN_W + QUOT_W - 1;
  localparam int DCNT_W   = $clog2(QUOT_W);
  localparam int STEP_W   = 3;
  localparam int WHEEL_W  = PWM_W + 3;

  // Arithmetic constants
  localparam int WRAP_HALF   = 2880;
  localparam int WRAP_FULL   = 5760;
  localparam int INTEG_LIMIT = 800000;
  localparam int DT_DEFAULT  = 20;
  localparam int SCALE_MS    = 1000;
  localparam int SCALE_D     = 1000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PID_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_IVL    = 3'd6;

  // Configuration reset values
  localparam logic              RST_PID_ENABLE = 1'b1;
  localparam logic [GAIN_W-1:0] RST_GAIN_P     = 16'd512;
  localparam logic [GAIN_W-1:0] RST_GAIN_I     = 16'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN_D     = 16'd0;
  localparam logic [PWM_W-1:0]  RST_CORR_LIMIT = 8'd50;
  localparam logic [PWM_W-1:0]  RST_RAMP_STEP  = 8'd10;
  localparam logic [MS_W-1:0]   RST_RAMP_IVL   = 16'd20;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;   // two's complement numerator
    logic [DEN_W-1:0]  den;   // positive denominator
  } div_req_t;

  typedef struct packed {
    logic              done;  // one-cycle pulse
    logic              neg;
    logic [QUOT_W-1:0] quot;  // saturating magnitude, any value >= 256 means clamp
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/hhpd_if.sv
// Valid/ready channel interfaces for tick beats and result beats.
// Depends on hhpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hhpd_in_if;
  import hhpd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] target_heading;
  logic signed [HEAD_W-1:0] current_heading;
  logic                     heading_valid;
  logic [MS_W-1:0]          elapsed_ms;
  logic [PWM_W-1:0]         target_speed;
  logic                     restart;
  logic                     force_stop;

  modport source (output valid, target_heading, current_heading, heading_valid, elapsed_ms,
                  target_speed, restart, force_stop, input ready);
  modport sink   (input valid, target_heading, current_heading, heading_valid, elapsed_ms,
                  target_speed, restart, force_stop, output ready);
endinterface

interface hhpd_out_if;
  import hhpd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PWM_W-1:0]         left_speed;
  logic [PWM_W-1:0]         right_speed;
  logic [PWM_W-1:0]         ramped_speed;
  logic signed [CORR_W-1:0] correction;

  modport source (output valid, left_speed, right_speed, ramped_speed, correction,
                  input ready);
  modport sink   (input valid, left_speed, right_speed, ramped_speed, correction,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/heading_hold_pid_drive_top.sv
// Heading-hold drive: speed ramp, heading PID sequencer and wheel mixing.
// Depends on hhpd_pkg, hhpd_if, hhpd_mul and hhpd_div.
//
// Usage
//   in_ch  : one control tick per beat (headings in 1/16 degree, elapsed ms,
//            target PWM speed, restart and force-stop flags).
//   out_ch : one result beat per tick: left, right and ramped PWM speed and
//            the clamped heading correction.
//   cfg_*  : plain write port, register index and data; write only while idle.
// Sequence
//   A tick that runs the PID goes from its accept edge to out_ch valid through
//   one preparation state, eight passes through the shared 34x30 multiplier,
//   one divider start and ten restoring-divide steps plus hand-off.
//   A tick with force_stop, PID disabled or heading invalid goes from the
//   preparation state straight to the done state. in_ch.ready is high only
//   while the sequencer is idle, so it takes a new tick only after the last.
// Reset
//   rst_n (synchronous, active low) loads the register defaults, zeroes speed,
//   timers, integral and last error, and drops out_ch.valid.
// Stalls
//   The result sits in an output register; a new tick is accepted while it
//   waits, and the next result waits in the sequencer until the beat leaves.
`timescale 1ns / 1ps
`default_nettype none

module heading_hold_pid_drive_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hhpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hhpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  hhpd_in_if.sink                            in_ch,
  hhpd_out_if.source                         out_ch
);
  import hhpd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIVS = 6'b001000,
    ST_DIVW = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // multiplier schedule; the T steps consume the product of the step before
  localparam logic [STEP_W-1:0] STEP_GP   = 3'd0;  // gain_p * 1000
  localparam logic [STEP_W-1:0] STEP_EDT  = 3'd1;  // e * dt
  localparam logic [STEP_W-1:0] STEP_T1   = 3'd2;  // (gain_p*1000) * (e*dt)
  localparam logic [STEP_W-1:0] STEP_GIDT = 3'd3;  // gain_i * dt
  localparam logic [STEP_W-1:0] STEP_T2   = 3'd4;  // (gain_i*dt) * integral
  localparam logic [STEP_W-1:0] STEP_GDDE = 3'd5;  // gain_d * de
  localparam logic [STEP_W-1:0] STEP_T3   = 3'd6;  // (gain_d*de) * 1e6
  localparam logic [STEP_W-1:0] STEP_DEN  = 3'd7;  // dt * 1000

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;

  // configuration registers
  logic              pid_en_r;
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [PWM_W-1:0]  corr_lim_r, ramp_step_r;
  logic [MS_W-1:0]   ramp_ivl_r;

  // latched tick
  logic signed [HEAD_W-1:0] tgt_r, cur_r;
  logic                     hv_r, rs_r, fs_r;
  logic [MS_W-1:0]          el_r;
  logic [PWM_W-1:0]         ts_r;

  // persistent controller state
  logic [PWM_W-1:0]          speed_r;
  logic [MS_W-1:0]           ramp_tmr_r, pid_tmr_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [HEAD_W-1:0]  last_err_r;

  // working registers of one PID pass
  logic signed [HEAD_W-1:0] e_r;
  logic signed [DE_W-1:0]   de_r;
  logic [MS_W-1:0]          dt_r;
  logic [T_W-1:0]           t_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [CORR_W-1:0] corr_r;

  // output register
  logic                     out_valid_r;
  logic [PWM_W-1:0]         out_left_r, out_right_r, out_ramped_r;
  logic signed [CORR_W-1:0] out_corr_r;

  logic in_accept, out_load;

  // ---------------------------------------------------------------------
  // Preparation: timers, ramp, wrapped error
  // ---------------------------------------------------------------------
  logic [MS_W:0]             ramp_sum, pid_sum;
  logic [MS_W-1:0]           ramp_sat, pid_base, pid_sat;
  logic                      ramp_fire, pid_run;
  logic [PWM_W:0]            spd_up, spd_dn;
  logic [PWM_W-1:0]          spd_stepped;
  logic signed [HDIFF_W-1:0] diff, e_wrap;
  logic signed [HEAD_W-1:0]  e_nxt, last_base;
  logic signed [DE_W-1:0]    de_nxt;

  assign ramp_sum  = (MS_W+1)'(ramp_tmr_r) + (MS_W+1)'(el_r);
  assign ramp_sat  = ramp_sum[MS_W] ? '1 : ramp_sum[MS_W-1:0];
  assign ramp_fire = ramp_sat >= ramp_ivl_r;

  // restart clears the PID timer before this tick's time is added
  assign pid_base  = rs_r ? '0 : pid_tmr_r;
  assign pid_sum   = (MS_W+1)'(pid_base) + (MS_W+1)'(el_r);
  assign pid_sat   = pid_sum[MS_W] ? '1 : pid_sum[MS_W-1:0];
  assign pid_run   = !fs_r && pid_en_r && hv_r;

  assign spd_up = (PWM_W+1)'(speed_r) + (PWM_W+1)'(ramp_step_r);
  assign spd_dn = (PWM_W+1)'(speed_r) - (PWM_W+1)'(ramp_step_r);

  // step toward the target, never past it
  always_comb begin
    priority if (speed_r < ts_r) begin
      spd_stepped = (spd_up > (PWM_W+1)'(ts_r)) ? ts_r : spd_up[PWM_W-1:0];
    end else if (speed_r > ts_r) begin
      spd_stepped = (spd_dn[PWM_W] || spd_dn[PWM_W-1:0] < ts_r) ? ts_r
                                                               : spd_dn[PWM_W-1:0];
    end else begin
      spd_stepped = speed_r;
    end
  end

  // one wrap step is enough for any pair of 13-bit headings
  assign diff = HDIFF_W'(tgt_r) - HDIFF_W'(cur_r);
  always_comb begin
    priority if (diff > WRAP_HALF) begin
      e_wrap = diff - HDIFF_W'(WRAP_FULL);
    end else if (diff < -WRAP_HALF) begin
      e_wrap = diff + HDIFF_W'(WRAP_FULL);
    end else begin
      e_wrap = diff;
    end
  end
  assign e_nxt     = e_wrap[HEAD_W-1:0];
  assign last_base = rs_r ? '0 : last_err_r;
  assign de_nxt    = DE_W'(e_nxt) - DE_W'(last_base);

  // ---------------------------------------------------------------------
  // Shared multiplier and its operand selection
  // ---------------------------------------------------------------------
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    unique case (step_r)
      STEP_GP: begin
        mul_a = MA_W'(gain_p_r);
        mul_b = MB_W'(SCALE_MS);
      end
      STEP_EDT: begin
        mul_a = MA_W'(e_r);
        mul_b = MB_W'(dt_r);
      end
      STEP_T1: begin
        mul_a = MA_W'(t_r);
        mul_b = MB_W'(signed'(prod[EDT_W-1:0]));
      end
      STEP_GIDT: begin
        mul_a = MA_W'(gain_i_r);
        mul_b = MB_W'(dt_r);
      end
      STEP_T2: begin
        mul_a = MA_W'(prod[GIDT_W-1:0]);
        mul_b = MB_W'(integ_r);
      end
      STEP_GDDE: begin
        mul_a = MA_W'(gain_d_r);
        mul_b = MB_W'(de_r);
      end
      STEP_T3: begin
        mul_a = MA_W'(signed'(prod[GDDE_W-1:0]));
        mul_b = MB_W'(SCALE_D);
      end
      STEP_DEN: begin
        mul_a = MA_W'(dt_r);
        mul_b = MB_W'(SCALE_MS);
      end
    endcase
  end

  hhpd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // integral update with clamp, fed by the e*dt product
  logic signed [ISUM_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_sat;

  assign isum = ISUM_W'(integ_r) + ISUM_W'(signed'(prod[EDT_W-1:0]));
  always_comb begin
    priority if (isum > INTEG_LIMIT) begin
      integ_sat = INTEG_W'(INTEG_LIMIT);
    end else if (isum < -INTEG_LIMIT) begin
      integ_sat = INTEG_W'(-INTEG_LIMIT);
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Divider: sum of terms over 4096000 * dt
  // ---------------------------------------------------------------------
  div_req_t  div_req;
  div_stat_t div_stat;

  assign div_req.start = state_r == ST_DIVS;
  assign div_req.num   = acc_r;
  assign div_req.den   = DEN_W'(prod[T_W-1:0]) << DEN_SHIFT;

  hhpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  // clamp the quotient to the correction limit, then apply the sign
  logic               q_sat;
  logic [PWM_W-1:0]   q_mag;
  logic [CORR_W-1:0]  q_mag9;
  logic [CORR_W-1:0]  corr_nxt;

  assign q_sat    = div_stat.quot > QUOT_W'(corr_lim_r);
  assign q_mag    = q_sat ? corr_lim_r : div_stat.quot[PWM_W-1:0];
  assign q_mag9   = CORR_W'(q_mag);
  assign corr_nxt = div_stat.neg ? (~q_mag9 + 1'b1) : q_mag9;

  // ---------------------------------------------------------------------
  // Wheel mixing: left loses the correction, right gains it
  // ---------------------------------------------------------------------
  logic [WHEEL_W-1:0] wl, wr;
  logic [PWM_W-1:0]   left_nxt, right_nxt;

  assign wl = WHEEL_W'(speed_r) - WHEEL_W'(corr_r);
  assign wr = WHEEL_W'(speed_r) + WHEEL_W'(corr_r);

  always_comb begin
    priority if (wl[WHEEL_W-1]) begin
      left_nxt = '0;
    end else if (|wl[WHEEL_W-2:PWM_W]) begin
      left_nxt = '1;
    end else begin
      left_nxt = wl[PWM_W-1:0];
    end
    priority if (wr[WHEEL_W-1]) begin
      right_nxt = '0;
    end else if (|wr[WHEEL_W-2:PWM_W]) begin
      right_nxt = '1;
    end else begin
      right_nxt = wr[PWM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_ch.ready = state_r == ST_IDLE;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_PREP;
      ST_PREP: state_nxt = pid_run ? ST_MUL : ST_DONE;
      ST_MUL:  if (step_r == STEP_DEN) state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_GP;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= STEP_GP;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_en_r    <= RST_PID_ENABLE;
      gain_p_r    <= RST_GAIN_P;
      gain_i_r    <= RST_GAIN_I;
      gain_d_r    <= RST_GAIN_D;
      corr_lim_r  <= RST_CORR_LIMIT;
      ramp_step_r <= RST_RAMP_STEP;
      ramp_ivl_r  <= RST_RAMP_IVL;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PID_ENABLE: pid_en_r    <= cfg_wdata[0];
        CFG_GAIN_P:     gain_p_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_CORR_LIMIT: corr_lim_r  <= cfg_wdata[PWM_W-1:0];
        CFG_RAMP_STEP:  ramp_step_r <= cfg_wdata[PWM_W-1:0];
        CFG_RAMP_IVL:   ramp_ivl_r  <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // latch the tick beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tgt_r <= in_ch.target_heading;
      cur_r <= in_ch.current_heading;
      hv_r  <= in_ch.heading_valid;
      el_r  <= in_ch.elapsed_ms;
      ts_r  <= in_ch.target_speed;
      rs_r  <= in_ch.restart;
      fs_r  <= in_ch.force_stop;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r    <= '0;
      ramp_tmr_r <= '0;
      pid_tmr_r  <= '0;
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (state_r == ST_PREP) begin
      // force stop drops the speed and holds the ramp; timers still run
      if (fs_r) begin
        speed_r    <= '0;
        ramp_tmr_r <= ramp_sat;
      end else if (ramp_fire) begin
        speed_r    <= spd_stepped;
        ramp_tmr_r <= '0;
      end else begin
        ramp_tmr_r <= ramp_sat;
      end
      pid_tmr_r  <= pid_run ? '0 : pid_sat;
      if (rs_r) begin
        integ_r <= '0;
      end
      last_err_r <= pid_run ? e_nxt : last_base;
    end else if (state_r == ST_MUL && step_r == STEP_T1) begin
      integ_r <= integ_sat;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_PREP: begin
        e_r    <= e_nxt;
        de_r   <= de_nxt;
        dt_r   <= (pid_sat == '0) ? MS_W'(DT_DEFAULT) : pid_sat;
        corr_r <= '0;
      end
      ST_MUL: begin
        unique case (step_r)
          STEP_EDT:  t_r   <= prod[T_W-1:0];
          STEP_GIDT: acc_r <= prod;
          STEP_GDDE: acc_r <= acc_r + prod;
          STEP_DEN:  acc_r <= acc_r + prod;
          default: ;
        endcase
      end
      ST_DIVW: begin
        if (div_stat.done) begin
          corr_r <= corr_nxt;
        end
      end
      default: ;
    endcase
  end

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r   <= left_nxt;
      out_right_r  <= right_nxt;
      out_ramped_r <= speed_r;
      out_corr_r   <= corr_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_speed   = out_left_r;
  assign out_ch.right_speed  = out_right_r;
  assign out_ch.ramped_speed = out_ramped_r;
  assign out_ch.correction   = out_corr_r;

endmodule

`default_nettype wire

### rtl/core/hhpd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hhpd_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module hhpd_mul (
  input  logic                             clk,
  input  logic signed [hhpd_pkg::MA_W-1:0] op_a,
  input  logic signed [hhpd_pkg::MB_W-1:0] op_b,
  output logic signed [hhpd_pkg::PROD_W-1:0] prod_r
);
  import hhpd_pkg::*;

  logic signed [MA_W+MB_W-1:0] full;

  assign full = op_a * op_b;

  // every product the sequencer asks for fits the kept width
  always_ff @(posedge clk) begin
    prod_r <= full[PROD_W-1:0];
  end

endmodule

`default_nettype wire

### rtl/core/hhpd_div.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on hhpd_pkg for widths and the div_req_t / div_stat_t types.
`timescale 1ns / 1ps
`default_nettype none

module hhpd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  hhpd_pkg::div_req_t  req,
  output hhpd_pkg::div_stat_t stat
);
  import hhpd_pkg::*;

  logic [REM_W-1:0]  rem_r;
  logic [DIVS_W-1:0] ds_r;
  logic [QUOT_W-1:0] quot_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              neg_r;

  logic [PROD_W-1:0] num_mag;
  logic [REM_W-1:0]  ds_ext;
  logic              fits;

  assign num_mag = req.num[PROD_W-1] ? (~req.num + 1'b1) : req.num;
  assign ds_ext  = REM_W'(ds_r);
  assign fits    = rem_r >= ds_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= num_mag[REM_W-1:0];
      ds_r   <= {req.den, (QUOT_W-1)'(0)};
      quot_r <= '0;
      cnt_r  <= DCNT_W'(QUOT_W - 1);
      neg_r  <= req.num[PROD_W-1];
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - ds_ext;
      end
      quot_r <= {quot_r[QUOT_W-2:0], fits};
      ds_r   <= ds_r >> 1;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign stat.done = done_r;
  assign stat.neg  = neg_r;
  assign stat.quot = quot_r;

endmodule

`default_nettype wire

### rtl/core/hhpd_chk.sv
// Port-level checks for heading_hold_pid_drive_top, attached by bind.
// Depends on hhpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module hhpd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hhpd_pkg::PWM_W-1:0]      left,
  input logic [hhpd_pkg::PWM_W-1:0]      right,
  input logic [hhpd_pkg::PWM_W-1:0]      ramped,
  input logic [hhpd_pkg::CORR_W-1:0]     corr
);
  import hhpd_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // one tick at a time: ready drops after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("tick beat accepted while busy");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left) && $stable(right) &&
                                $stable(ramped) && $stable(corr))
    else $error("stalled result beat changed");

  // the wheels straddle the ramped speed on the side the correction gives
  a_wheel_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (corr[CORR_W-1] ? (left >= ramped && right <= ramped)
                                  : (left <= ramped && right >= ramped)))
    else $error("wheel speeds inconsistent with correction");

endmodule

bind heading_hold_pid_drive_top hhpd_chk u_hhpd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left      (out_ch.left_speed),
  .right     (out_ch.right_speed),
  .ramped    (out_ch.ramped_speed),
  .corr      (out_ch.correction)
);

`default_nettype wire

### tb/hhpd_drive_checker.sv
// Scoreboard for the heading-hold drive block: watches the tick, result and register
// ports, predicts every result beat and compares it field by field.
// Depends on hhpd_pkg and the channel interfaces of hhpd_if.
`timescale 1ns / 1ps

module hhpd_drive_checker
  import hhpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hhpd_in_if                    in_ch,
  hhpd_out_if                   out_ch,
  output int                    fail_count,
  output int                    pending
);

  localparam longint HALF_TURN    = 2880;
  localparam longint FULL_TURN    = 5760;
  localparam longint INTEG_CAP    = 800000;
  localparam longint DT_FALLBACK  = 20;
  localparam longint MS_PER_S     = 1000;
  localparam longint D_SCALE      = 1000000;
  localparam longint DIVISOR_BASE = 4096000;
  localparam longint PWM_MAX      = 255;

  typedef struct {
    int left;
    int right;
    int ramped;
    int corr;
  } drive_beat_t;

  // Register copy
  logic              pid_on;
  logic [GAIN_W-1:0] kp, ki, kd;
  logic [PWM_W-1:0]  corr_cap, ramp_stp;
  logic [MS_W-1:0]   ramp_ivl;

  // Controller state copy
  logic [PWM_W-1:0] speed_now;
  logic [MS_W-1:0]  ramp_ms, pid_ms;
  longint           integ_sum, prev_err;

  drive_beat_t wheel_q[$];
  drive_beat_t due;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [MS_W-1:0] add_ms(logic [MS_W-1:0] a, logic [MS_W-1:0] b);
    logic [MS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
  endfunction

  // Advance the controller by one tick and return the wheel beat it produces.
  function automatic drive_beat_t drive_step(logic signed [HEAD_W-1:0] tgt,
                                             logic signed [HEAD_W-1:0] cur,
                                             logic hv, logic [MS_W-1:0] ms,
                                             logic [PWM_W-1:0] tspd, logic rs, logic st);
    drive_beat_t r;
    longint tv, cv, e, dt, de, num, c, spd, goal, stp, kpv, kiv, kdv, lim;
    tv = tgt;
    cv = cur;
    goal = tspd;
    stp = ramp_stp;
    kpv = kp;
    kiv = ki;
    kdv = kd;
    lim = corr_cap;
    c = 0;

    if (rs) begin
      integ_sum = 0;
      prev_err = 0;
      pid_ms = '0;
    end
    ramp_ms = add_ms(ramp_ms, ms);
    pid_ms = add_ms(pid_ms, ms);

    if (st) begin
      speed_now = '0;
      r.left = 0;
      r.right = 0;
      r.ramped = 0;
      r.corr = 0;
      return r;
    end

    if (ramp_ms >= ramp_ivl) begin
      ramp_ms = '0;
      spd = speed_now;
      if (spd < goal) begin
        spd = spd + stp;
        if (spd > goal) spd = goal;
      end else if (spd > goal) begin
        spd = spd - stp;
        if (spd < goal) spd = goal;
      end
      speed_now = spd[PWM_W-1:0];
    end

    if (pid_on && hv) begin
      e = tv - cv;
      while (e > HALF_TURN) e = e - FULL_TURN;
      while (e < -HALF_TURN) e = e + FULL_TURN;
      if (pid_ms == '0) dt = DT_FALLBACK;
      else dt = pid_ms;
      pid_ms = '0;
      integ_sum = clip(integ_sum + e * dt, -INTEG_CAP, INTEG_CAP);
      de = e - prev_err;
      prev_err = e;
      num = kpv * e * MS_PER_S * dt + kiv * integ_sum * dt + kdv * de * D_SCALE;
      c = clip(num / (DIVISOR_BASE * dt), -lim, lim);
    end

    spd = speed_now;
    r.left = int'(clip(spd - c, 0, PWM_MAX));
    r.right = int'(clip(spd + c, 0, PWM_MAX));
    r.ramped = int'(spd);
    r.corr = int'(c);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pid_on = RST_PID_ENABLE;
      kp = RST_GAIN_P;
      ki = RST_GAIN_I;
      kd = RST_GAIN_D;
      corr_cap = RST_CORR_LIMIT;
      ramp_stp = RST_RAMP_STEP;
      ramp_ivl = RST_RAMP_IVL;
      speed_now = '0;
      ramp_ms = '0;
      pid_ms = '0;
      integ_sum = 0;
      prev_err = 0;
      fail_count = 0;
      wheel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PID_ENABLE: pid_on = cfg_wdata[0];
          CFG_GAIN_P:     kp = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_I:     ki = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_D:     kd = cfg_wdata[GAIN_W-1:0];
          CFG_CORR_LIMIT: corr_cap = cfg_wdata[PWM_W-1:0];
          CFG_RAMP_STEP:  ramp_stp = cfg_wdata[PWM_W-1:0];
          CFG_RAMP_IVL:   ramp_ivl = cfg_wdata[MS_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (wheel_q.size() == 0) begin
          $error("result beat with no tick waiting");
          fail_count++;
        end else begin
          due = wheel_q.pop_front();
          check_field("left_speed", due.left, int'(out_ch.left_speed));
          check_field("right_speed", due.right, int'(out_ch.right_speed));
          check_field("ramped_speed", due.ramped, int'(out_ch.ramped_speed));
          check_field("correction", due.corr, int'(out_ch.correction));
        end
      end
      if (in_ch.valid && in_ch.ready)
        wheel_q.push_back(drive_step(in_ch.target_heading, in_ch.current_heading,
                                     in_ch.heading_valid, in_ch.elapsed_ms,
                                     in_ch.target_speed, in_ch.restart, in_ch.force_stop));
    end
    pending <= wheel_q.size();
  end

endmodule

### tb/tb_heading_hold_pid_drive_top.sv
// Top of the heading-hold drive testbench: clock, reset, register set-up, tick
// stimulus and result back-pressure. Depends on hhpd_pkg, hhpd_if, the block
// and hhpd_drive_checker, which predicts and compares every result beat.
`timescale 1ns / 1ps

module tb_heading_hold_pid_drive_top;
  import hhpd_pkg::*;

  localparam int HEADING_MAX = 2880;      // half a turn in 1/16 degree
  localparam int CYCLE_LIMIT = 400000;    // many times the slowest legal run
  localparam int PHASE_TICKS = 72;
  localparam int DRAIN_CYCLES = 40;       // comfortably above the PID path

  // Receiver stall patterns
  localparam logic [1:0] RX_OPEN   = 2'd0;  // ready every cycle
  localparam logic [1:0] RX_COIN   = 2'd1;  // ready on a coin toss
  localparam logic [1:0] RX_SPARSE = 2'd2;  // ready one cycle in five
  localparam logic [1:0] RX_BURSTY = 2'd3;  // long stall, short open window

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fails;
  int                    pending;
  int                    cycles = 0;
  logic [1:0]            rx_mode;
  logic [5:0]            rx_cnt;
  logic [PWM_W-1:0]      held_speed;

  hhpd_in_if  in_ch ();
  hhpd_out_if out_ch ();

  heading_hold_pid_drive_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  hhpd_drive_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stop a hung run: the block never answering must not stall the simulator.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_heading_hold_pid_drive_top: FAIL");
      $finish;
    end
  end

  // Result back-pressure. Pick a fresh stall pattern each time rx_cnt wraps so stalls land
  // on every phase of the sequencer, with open stretches in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_cnt <= '0;
    end else begin
      rx_cnt <= rx_cnt + 6'd1;
      if (rx_cnt == 6'd63) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= (rx_cnt % 5 == 0);
        default:   out_ch.ready <= (rx_cnt[3:2] == 2'b11);
      endcase
    end
  end

  // Offer one tick beat and hold it until the block takes it. Leave valid high on
  // return, so a following beat goes out back to back.
  task automatic send_tick(input logic signed [HEAD_W-1:0] tgt,
                           input logic signed [HEAD_W-1:0] cur,
                           input logic hv, input logic [MS_W-1:0] ms,
                           input logic [PWM_W-1:0] spd, input logic rs, input logic st);
    in_ch.valid <= 1'b1;
    in_ch.target_heading <= tgt;
    in_ch.current_heading <= cur;
    in_ch.heading_valid <= hv;
    in_ch.elapsed_ms <= ms;
    in_ch.target_speed <= spd;
    in_ch.restart <= rs;
    in_ch.force_stop <= st;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold off until every predicted beat has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Load the whole register set; only called with the block idle.
  task automatic apply_settings(input logic en, input logic [GAIN_W-1:0] p,
                                input logic [GAIN_W-1:0] i, input logic [GAIN_W-1:0] d,
                                input logic [PWM_W-1:0] lim, input logic [PWM_W-1:0] step,
                                input logic [MS_W-1:0] ivl);
    write_cfg(CFG_PID_ENABLE, CFG_DATA_W'(en));
    write_cfg(CFG_GAIN_P, p);
    write_cfg(CFG_GAIN_I, i);
    write_cfg(CFG_GAIN_D, d);
    write_cfg(CFG_CORR_LIMIT, CFG_DATA_W'(lim));
    write_cfg(CFG_RAMP_STEP, CFG_DATA_W'(step));
    write_cfg(CFG_RAMP_IVL, ivl);
    cfg_we <= 1'b0;
  endtask

  // Random ticks in bursts. Most look like a real drive (small elapsed times, a
  // held target speed); four in ten put the current heading close to the target.
  // Others bring wild headings, sensor dropouts, long gaps, restarts and stops.
  task automatic run_random(input int n, input bit quiet);
    int sent, burst, gap, tv, cv;
    logic [MS_W-1:0] ms;
    logic hv, rs, st;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n; k++) begin
        case ($urandom_range(0, 9))
          0:       tv = HEADING_MAX;
          1:       tv = -HEADING_MAX;
          default: tv = int'($urandom_range(0, 2 * HEADING_MAX)) - HEADING_MAX;
        endcase
        case ($urandom_range(0, 9))
          0:       cv = HEADING_MAX;
          1:       cv = -HEADING_MAX;
          2, 3, 4, 5: begin
            cv = tv + int'($urandom_range(0, 160)) - 80;
            if (cv > HEADING_MAX) cv = HEADING_MAX;
            if (cv < -HEADING_MAX) cv = -HEADING_MAX;
          end
          default: cv = int'($urandom_range(0, 2 * HEADING_MAX)) - HEADING_MAX;
        endcase
        case ($urandom_range(0, 19))
          0:       ms = '0;
          1:       ms = MS_W'($urandom_range(60000, 65535));
          2, 3:    ms = MS_W'($urandom_range(0, 2000));
          default: ms = MS_W'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
          0:       held_speed = '0;
          1:       held_speed = '1;
          2, 3:    held_speed = PWM_W'($urandom_range(0, 255));
          default: ;
        endcase
        hv = ($urandom_range(0, 9) != 0);
        rs = ($urandom_range(0, 24) == 0);
        st = ($urandom_range(0, 19) == 0);
        send_tick(tv[HEAD_W-1:0], cv[HEAD_W-1:0], hv, ms, held_speed, rs, st);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        settle();
      end else if (!quiet) begin
        gap = $urandom_range(0, 15);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.target_heading <= '0;
    in_ch.current_heading <= '0;
    in_ch.heading_valid <= 1'b0;
    in_ch.elapsed_ms <= '0;
    in_ch.target_speed <= '0;
    in_ch.restart <= 1'b0;
    in_ch.force_stop <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_PID_ENABLE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    held_speed = 8'd128;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks on the reset register set (P gain 2.0, limit 50, step 10
    // every 20 ms).
    send_tick(13'sd0, 13'sd0, 1'b1, 16'd0, 8'd0, 1'b0, 1'b0);           // all quiet
    send_tick(13'sd0, 13'sd0, 1'b0, 16'd0, 8'd0, 1'b0, 1'b1);           // stop at rest
    send_tick(13'sd2880, -13'sd2880, 1'b1, 16'd20, 8'd255, 1'b0, 1'b0); // full turn wraps to 0
    send_tick(13'sd2880, -13'sd1, 1'b1, 16'd20, 8'd255, 1'b0, 1'b0);    // wraps negative
    send_tick(-13'sd2880, 13'sd1, 1'b1, 16'd20, 8'd255, 1'b0, 1'b0);    // wraps positive
    send_tick(13'sd2880, 13'sd0, 1'b1, 16'd20, 8'd255, 1'b0, 1'b0);     // largest error
    send_tick(-13'sd2880, 13'sd0, 1'b1, 16'd5, 8'd255, 1'b0, 1'b0);     // no ramp step
    send_tick(13'sd100, 13'sd0, 1'b0, 16'd15, 8'd255, 1'b0, 1'b0);      // sensor dropout
    send_tick(13'sd100, 13'sd0, 1'b1, 16'd0, 8'd255, 1'b1, 1'b0);       // restart, dt falls back
    send_tick(13'sd100, 13'sd0, 1'b1, 16'hFFFF, 8'd255, 1'b0, 1'b0);    // largest elapsed time
    send_tick(13'sd100, 13'sd0, 1'b1, 16'hFFFF, 8'd255, 1'b0, 1'b0);
    send_tick(13'sd0, 13'sd100, 1'b1, 16'd10, 8'd0, 1'b0, 1'b0);        // ramp down
    send_tick(13'sd0, 13'sd100, 1'b1, 16'hFFFF, 8'd0, 1'b0, 1'b0);
    send_tick(13'sd50, 13'sd0, 1'b1, 16'd30, 8'd128, 1'b1, 1'b1);       // stop with restart
    send_tick(-13'sd2880, 13'sd2880, 1'b1, 16'd25, 8'd128, 1'b0, 1'b0); // full turn the other way
    send_tick(13'sd1365, -13'sd1366, 1'b1, 16'hAAAA, 8'd170, 1'b0, 1'b0);
    send_tick(-13'sd1366, 13'sd1365, 1'b1, 16'h5555, 8'd85, 1'b0, 1'b0);
    send_tick(13'sd0, 13'sd0, 1'b1, 16'd20, 8'd5, 1'b0, 1'b0);          // ramp steps toward a low target
    settle();

    // Register phases, extremes first. Every phase starts from an idle block.
    apply_settings(1'b1, 16'hFFFF, 16'd0, 16'd0, 8'd255, 8'd255, 16'd0);
    run_random(PHASE_TICKS, 1'b1);
    settle();
    apply_settings(1'b1, GAIN_W'($urandom_range(0, 2047)), GAIN_W'($urandom_range(0, 4095)),
                   GAIN_W'($urandom_range(0, 8191)), PWM_W'($urandom_range(20, 255)),
                   PWM_W'($urandom_range(1, 40)), MS_W'($urandom_range(0, 60)));
    run_random(PHASE_TICKS, 1'b0);
    settle();
    apply_settings(1'b0, 16'd512, 16'd100, 16'd100, 8'd50, 8'd10, 16'd20);
    run_random(PHASE_TICKS, 1'b0);
    settle();
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd1, 16'hFFFF);
    run_random(PHASE_TICKS, 1'b0);
    settle();
    // A zero step freezes the speed wherever the ramp left it.
    apply_settings(1'b1, GAIN_W'($urandom_range(0, 4095)), GAIN_W'($urandom_range(0, 4095)),
                   GAIN_W'($urandom_range(0, 4095)), PWM_W'($urandom_range(0, 255)), 8'd0,
                   MS_W'($urandom_range(0, 30)));
    run_random(PHASE_TICKS, 1'b0);
    settle();
    apply_settings(1'b1, GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                   GAIN_W'($urandom_range(0, 65535)), PWM_W'($urandom_range(0, 255)),
                   PWM_W'($urandom_range(1, 255)), MS_W'($urandom_range(0, 100)));
    run_random(PHASE_TICKS, 1'b1);
    settle();
    apply_settings(1'b1, GAIN_W'($urandom_range(256, 1536)), GAIN_W'($urandom_range(0, 512)),
                   GAIN_W'($urandom_range(0, 1024)), PWM_W'($urandom_range(10, 120)),
                   PWM_W'($urandom_range(1, 20)), MS_W'($urandom_range(0, 40)));
    run_random(PHASE_TICKS, 1'b0);
    settle();

    // Hold a little longer to catch any stray beat the block might still emit.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_heading_hold_pid_drive_top: PASS");
    end else begin
      $display("tb_heading_hold_pid_drive_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/hhpd_pkg.sv
rtl/core/hhpd_if.sv
rtl/core/hhpd_mul.sv
rtl/core/hhpd_div.sv
rtl/core/heading_hold_pid_drive_top.sv
rtl/core/hhpd_chk.sv
tb/hhpd_drive_checker.sv
tb/tb_heading_hold_pid_drive_top.sv
